// ===== rtl/core/gelu_activation_unit_top_macros.svh =====
// Assertion macros used by the checker of the GELU unit.
`ifndef GELU_ACTIVATION_UNIT_TOP_MACROS_SVH
`define GELU_ACTIVATION_UNIT_TOP_MACROS_SVH

// same-cycle implication
`define GAU_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("gau: assertion failed");

// next-cycle implication
`define GAU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("gau: assertion failed");

`endif

// ===== rtl/core/gau_pkg.sv =====
package gau_pkg;

  localparam int DATA_WIDTH     = 16;
  localparam int FRAC_BITS      = 12;
  localparam int TABLE_SEGMENTS = 256;

  localparam int PHI_BITS     = 16;
  localparam int PHI_W        = PHI_BITS + 1;
  localparam int ROM_DEPTH    = TABLE_SEGMENTS + 1;
  localparam int ROM_AW       = $clog2(ROM_DEPTH);
  localparam int POS_FRAC     = FRAC_BITS + 2;
  localparam int POS_W        = DATA_WIDTH + $clog2(TABLE_SEGMENTS) + 1;
  localparam int PROD_W       = PHI_W + POS_FRAC;
  localparam int YPROD_W      = DATA_WIDTH + PHI_W;
  localparam int RND_W        = YPROD_W + 1 - PHI_BITS;
  localparam int NUM_STAGES   = 6;
  localparam int SERIES_LIMIT = 512;

  localparam logic [63:0] INV_SQRT_2PI_Q32 = 64'd1713444047;

  // lowest GELU value is about -0.17; bound with margin
  localparam int GELU_FLOOR = -((18 << FRAC_BITS) / 100);

  typedef logic [PHI_W-1:0] phi_t;
  typedef phi_t phi_rom_t [ROM_DEPTH];

  localparam phi_t PHI_ONE = phi_t'(1) << PHI_BITS;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
    logic [NUM_STAGES-1:0] valid;
  } pipe_ctrl_t;

  // Phi(4k/TABLE_SEGMENTS) in Q1.16 from the erf Taylor series in Q32
  function automatic phi_t phi_point(input int unsigned k);
    logic [63:0]        kk;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        phi32;
    logic [63:0]        q;
    int                 n;
    kk   = 64'(k);
    term = ((64'd4 * kk) << 32) / 64'(TABLE_SEGMENTS);
    sum  = signed'(term);
    for (n = 1; (n < SERIES_LIMIT) && (term != 64'd0); n++) begin
      term = term * kk / 64'(TABLE_SEGMENTS);
      term = term * kk / 64'(TABLE_SEGMENTS);
      term = term * 64'd8 / 64'(n);
      if (n[0]) begin
        sum = sum - signed'(term / 64'(2 * n + 1));
      end else begin
        sum = sum + signed'(term / 64'(2 * n + 1));
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    phi32 = (64'd1 << 31) + ((64'(sum) * INV_SQRT_2PI_Q32) >> 32);
    q     = (phi32 + (64'd1 << (31 - PHI_BITS))) >> (32 - PHI_BITS);
    if (q > (64'd1 << PHI_BITS)) begin
      q = 64'd1 << PHI_BITS;
    end
    return phi_t'(q);
  endfunction

  function automatic phi_rom_t build_phi_rom();
    phi_rom_t rom;
    for (int k = 0; k < ROM_DEPTH; k++) begin
      rom[k] = phi_point(k);
      if ((k > 0) && (rom[k] < rom[k-1])) begin
        rom[k] = rom[k-1];
      end
    end
    return rom;
  endfunction

  localparam phi_rom_t PHI_ROM = build_phi_rom();

endpackage

// ===== rtl/core/gau_in_if.sv =====
interface gau_in_if;
  import gau_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

// ===== rtl/core/gau_out_if.sv =====
interface gau_out_if;
  import gau_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== rtl/core/gelu_activation_unit_top.sv =====
// Channel   Dir  Modport  Payload
// in_i      in   sink     sample_in  (signed Q4.12)
// out_o     out  source   sample_out (signed Q4.12)
//
// Six register stages, one word per cycle when the output does not stall.
// Stages: magnitude/index, ROM read, slope multiply, interpolate, x*Phi, round.
// Reset clears only the stage valid bits; no start-up sweep, the ROM is logic.
// A stall holds each full stage; empty stages still fill, so words keep
// entering until the pipe is full.
module gelu_activation_unit_top (
  input  logic clk_i,
  input  logic rst_ni,
  gau_in_if.sink    in_i,
  gau_out_if.source out_o
);
  import gau_pkg::*;

  pipe_ctrl_t ctrl;

  gau_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .in_ready_o  (in_i.ready),
    .ctrl_o      (ctrl)
  );

  // stage 1: magnitude and table position
  logic [DATA_WIDTH-1:0] in_v;
  logic                  s1_neg_d, s1_neg_q;
  logic                  s1_big_d, s1_big_q;
  logic [DATA_WIDTH-1:0] s1_mag_d, s1_mag_q;
  logic [ROM_AW-1:0]     s1_idx_d, s1_idx_q;
  logic [POS_FRAC-1:0]   s1_frac_d, s1_frac_q;
  logic [POS_W-1:0]      pos;
  logic [POS_W-1:0]      pos_idx;

  always_comb begin
    in_v      = in_i.sample_in;
    s1_neg_d  = in_v[DATA_WIDTH-1];
    s1_mag_d  = s1_neg_d ? DATA_WIDTH'(~in_v + 1'b1) : in_v;
    s1_big_d  = POS_W'(s1_mag_d) >= (POS_W'(4) << FRAC_BITS);
    pos       = POS_W'(s1_mag_d) * POS_W'(TABLE_SEGMENTS);
    pos_idx   = pos >> POS_FRAC;
    s1_frac_d = pos[POS_FRAC-1:0];
    if (pos_idx > POS_W'(TABLE_SEGMENTS - 1)) begin
      s1_idx_d = ROM_AW'(TABLE_SEGMENTS - 1);
    end else begin
      s1_idx_d = pos_idx[ROM_AW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load[0]) begin
      s1_neg_q  <= s1_neg_d;
      s1_big_q  <= s1_big_d;
      s1_mag_q  <= s1_mag_d;
      s1_idx_q  <= s1_idx_d;
      s1_frac_q <= s1_frac_d;
    end
  end

  // stage 2: neighbouring ROM points
  phi_t                  s2_r0_d, s2_r0_q;
  phi_t                  s2_diff_d, s2_diff_q;
  phi_t                  s2_r1;
  logic [ROM_AW-1:0]     s2_idx1;
  logic                  s2_neg_q, s2_big_q;
  logic [DATA_WIDTH-1:0] s2_mag_q;
  logic [POS_FRAC-1:0]   s2_frac_q;

  always_comb begin
    s2_idx1   = s1_idx_q + 1'b1;
    s2_r0_d   = PHI_ROM[s1_idx_q];
    s2_r1     = PHI_ROM[s2_idx1];
    s2_diff_d = s2_r1 - s2_r0_d;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load[1]) begin
      s2_r0_q   <= s2_r0_d;
      s2_diff_q <= s2_diff_d;
      s2_neg_q  <= s1_neg_q;
      s2_big_q  <= s1_big_q;
      s2_mag_q  <= s1_mag_q;
      s2_frac_q <= s1_frac_q;
    end
  end

  // stage 3: slope times fraction
  logic [PROD_W-1:0]     s3_prod_d, s3_prod_q;
  phi_t                  s3_r0_q;
  logic                  s3_neg_q, s3_big_q;
  logic [DATA_WIDTH-1:0] s3_mag_q;

  assign s3_prod_d = PROD_W'(s2_diff_q) * PROD_W'(s2_frac_q);

  always_ff @(posedge clk_i) begin
    if (ctrl.load[2]) begin
      s3_prod_q <= s3_prod_d;
      s3_r0_q   <= s2_r0_q;
      s3_neg_q  <= s2_neg_q;
      s3_big_q  <= s2_big_q;
      s3_mag_q  <= s2_mag_q;
    end
  end

  // stage 4: Phi(x), folded for negative x
  logic [PROD_W:0]       s4_rnd;
  phi_t                  s4_interp;
  phi_t                  s4_phi_abs;
  phi_t                  s4_phi_d, s4_phi_q;
  logic                  s4_neg_q;
  logic [DATA_WIDTH-1:0] s4_mag_q;

  always_comb begin
    s4_rnd     = (PROD_W+1)'(s3_prod_q) + ((PROD_W+1)'(1) << (POS_FRAC - 1));
    s4_interp  = s3_r0_q + PHI_W'(s4_rnd >> POS_FRAC);
    s4_phi_abs = s3_big_q ? PHI_ONE : s4_interp;
    s4_phi_d   = s3_neg_q ? (PHI_ONE - s4_phi_abs) : s4_phi_abs;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load[3]) begin
      s4_phi_q <= s4_phi_d;
      s4_neg_q <= s3_neg_q;
      s4_mag_q <= s3_mag_q;
    end
  end

  // stage 5: |x| * Phi
  logic [YPROD_W-1:0] s5_yprod_d, s5_yprod_q;
  logic               s5_neg_q;

  assign s5_yprod_d = YPROD_W'(s4_mag_q) * YPROD_W'(s4_phi_q);

  always_ff @(posedge clk_i) begin
    if (ctrl.load[4]) begin
      s5_yprod_q <= s5_yprod_d;
      s5_neg_q   <= s4_neg_q;
    end
  end

  // stage 6: round half away from zero, clamp, restore sign
  localparam logic [RND_W-1:0] SIGN_R = RND_W'(1) << (DATA_WIDTH - 1);

  logic [YPROD_W:0]      s6_sum;
  logic [RND_W-1:0]      s6_r;
  logic [RND_W-1:0]      s6_clip;
  logic [DATA_WIDTH-1:0] s6_res_d, s6_res_q;

  always_comb begin
    s6_sum = (YPROD_W+1)'(s5_yprod_q) + ((YPROD_W+1)'(1) << (PHI_BITS - 1));
    s6_r   = RND_W'(s6_sum >> PHI_BITS);
    if (s5_neg_q) begin
      s6_clip  = (s6_r > SIGN_R) ? SIGN_R : s6_r;
      s6_res_d = DATA_WIDTH'(RND_W'(0) - s6_clip);
    end else begin
      s6_clip  = (s6_r > (SIGN_R - 1'b1)) ? (SIGN_R - 1'b1) : s6_r;
      s6_res_d = DATA_WIDTH'(s6_clip);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load[5]) begin
      s6_res_q <= s6_res_d;
    end
  end

  assign out_o.valid      = ctrl.valid[NUM_STAGES-1];
  assign out_o.sample_out = s6_res_q;
endmodule

// ===== rtl/core/gau_pipe_ctrl.sv =====
module gau_pipe_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               out_ready_i,
  output logic               in_ready_o,
  output gau_pkg::pipe_ctrl_t ctrl_o
);
  import gau_pkg::*;

  logic [NUM_STAGES-1:0] valid_q;
  logic [NUM_STAGES-1:0] valid_d;
  logic [NUM_STAGES-1:0] load;

  // a stage loads when empty or when the one after it moves on
  always_comb begin
    load[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || out_ready_i;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      load[i] = !valid_q[i] || load[i+1];
    end
    valid_d[0] = load[0] ? in_valid_i : valid_q[0];
    for (int i = 1; i < NUM_STAGES; i++) begin
      valid_d[i] = load[i] ? valid_q[i-1] : valid_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o   = load[0];
  assign ctrl_o.load  = load;
  assign ctrl_o.valid = valid_q;
endmodule

// ===== rtl/core/gau_checker.sv =====
`include "gelu_activation_unit_top_macros.svh"

module gau_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_ready_i,
  input logic                                  out_valid_i,
  input logic                                  out_ready_i,
  input logic signed [gau_pkg::DATA_WIDTH-1:0] out_sample_i
);
  import gau_pkg::*;

  // a stalled result word holds
  `GAU_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, (out_valid_i && !out_ready_i),
    (out_valid_i && $stable(out_sample_i)))

  // with nothing waiting at the output the pipe cannot be full
  `GAU_ASSERT_NOW(a_in_free, clk_i, rst_ni, (!out_valid_i), (in_ready_i))

  // GELU never dips much below -0.17
  `GAU_ASSERT_NOW(a_out_floor, clk_i, rst_ni, (out_valid_i),
    ($signed(out_sample_i) >= GELU_FLOOR))

  // an idle, unstalled pipe drains and stays empty
  `GAU_ASSERT_NEXT(a_no_phantom, clk_i, rst_ni,
    (!in_valid_i && !out_valid_i && $past(!out_valid_i) && $past(!in_valid_i)
     && $past(!in_valid_i, 2) && $past(!in_valid_i, 3) && $past(!in_valid_i, 4)
     && $past(!in_valid_i, 5) && $past(!in_valid_i, 6)),
    (!out_valid_i))
endmodule

bind gelu_activation_unit_top gau_checker u_gau_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_sample_i (out_o.sample_out)
);
